@@ hw/rtl/hbges_pkg.sv @@
package hbges_pkg;

	// Bridge operating mode reported per result and kept per phase
	typedef enum logic [2:0] {
		BM_DISABLED = 3'd0,
		BM_REGULAR  = 3'd1,
		BM_INT_LOW  = 3'd2,
		BM_INT_HIGH = 3'd3,
		BM_FLAT_HS  = 3'd4,
		BM_FLAT_LS  = 3'd5
	} bm_t;

	// Requested switching mode; the two other codes disable the bridge
	typedef enum logic [1:0] {
		MODE_OFF    = 2'd0,
		MODE_HS_LED = 2'd1,
		MODE_LS_LED = 2'd2,
		MODE_OFF_HI = 2'd3
	} mode_t;

	// Configuration register indexes
	localparam int CFG_IDX_BITS = 3;
	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_PERIOD_TICKS   = 3'd0,
		CFG_OFF_TICK       = 3'd1,
		CFG_MIN_ON_TICKS   = 3'd2,
		CFG_MIN_OFF_TICKS  = 3'd3,
		CFG_FLAT_THRESHOLD = 3'd4
	} cfg_idx_t;

	localparam logic [15:0] RST_PERIOD_TICKS   = 16'd1000;
	localparam logic [15:0] RST_OFF_TICK       = 16'd1000;
	localparam logic [15:0] RST_MIN_ON_TICKS   = 16'd0;
	localparam logic [15:0] RST_MIN_OFF_TICKS  = 16'd0;
	localparam logic [15:0] RST_FLAT_THRESHOLD = 16'hFFFF;

	typedef struct packed {
		logic [16:0] duty_high;
		logic [16:0] duty_low;
		logic [1:0]  mode;
		logic [1:0]  phase;
		logic [11:0] dead_hs_to_ls;
		logic [11:0] dead_ls_to_hs;
	} req_t;

	typedef struct packed {
		logic [1:0]  phase_out;
		logic [15:0] hs_rise;
		logic [15:0] hs_fall;
		logic [15:0] ls_rise;
		logic [15:0] ls_fall;
		logic [2:0]  bridge_mode;
	} rsp_t;

	// Pulse decisions handed from stage 2 to the edge stage
	typedef struct packed {
		logic int_low;
		logic int_high;
		logic flat_hs;
		logic flat_ls;
	} dec_t;

endpackage

@@ hw/rtl/halfbridge_gate_edge_scheduler.sv @@
// Half-bridge gate edge scheduler (complementary PWM with dead-time insertion).
// Request channel (req_valid/req_ready/req): one phase update with high- and
// low-side duties (unsigned Q1.16), mode, phase index and two dead times.
// Response channel (rsp_valid/rsp_ready/rsp): rise and fall ticks of both
// switches for one period, plus the resulting bridge mode. A request whose
// phase is not below PHASES is taken and dropped without a response.
// Configuration channel (cfg_valid/cfg_ready/cfg_index/cfg_data): always
// ready; write only while no request is in flight.
// Path: the input register, the count stage with four multipliers, the decision
// stage, the edge stage and the output register. Throughput: one request per
// cycle while the receiver does not stall, set by the four-stage pipe.
// A stalled receiver holds the output register; each stage still fills its
// empty slot, so up to four requests queue before req_ready drops.
// Reset clears the pipeline valids, loads the configuration defaults and sets
// every phase's stored mode to disabled.
module halfbridge_gate_edge_scheduler #(
	parameter int PHASES    = 3,
	parameter int TICK_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                req_valid,
	output logic                                req_ready,
	input  hbges_pkg::req_t                     req,
	output logic                                rsp_valid,
	input  logic                                rsp_ready,
	output hbges_pkg::rsp_t                     rsp,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [hbges_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [15:0]                         cfg_data
);
	import hbges_pkg::*;

	localparam int PH_BITS = (PHASES > 1) ? $clog2(PHASES) : 1;
	localparam int CW      = (TICK_BITS > 16) ? TICK_BITS : 16;
	localparam int PW      = TICK_BITS + 17;

	// Configuration registers
	logic [15:0] period_q;
	logic [15:0] off_tick_q;
	logic [15:0] min_on_q;
	logic [15:0] min_off_q;
	logic [15:0] flat_thr_q;

	// Pipeline
	logic                 v_s1, v_s2, v_s3, rsp_valid_q;
	req_t                 req_s1, req_s2, req_s3;
	logic [TICK_BITS-1:0] ch_a_s2, cl_a_s2, ch_f_s2, cl_f_s2;
	logic [TICK_BITS-1:0] ch_s3, cl_s3;
	dec_t                 dec_s3;
	rsp_t                 rsp_q;
	bm_t                  bridge_state_q [PHASES];

	logic                 rdy_s1, rdy_s2, rdy_s3;
	logic                 phase_ok;
	logic [TICK_BITS-1:0] full, avail;
	logic [PW-1:0]        p_ch_a, p_cl_a, p_ch_f, p_cl_f;
	logic [TICK_BITS-1:0] tmax_t;
	logic [TICK_BITS-1:0] ch1, cl1, ch2, cl2, ch3, cl3;
	dec_t                 dec;
	logic [PH_BITS-1:0]   ph_s3;
	bm_t                  prev;
	rsp_t                 rsp_d;

	// Handshake: each stage moves when its successor has room
	assign rdy_s3    = !rsp_valid_q || rsp_ready;
	assign rdy_s2    = !v_s3 || rdy_s3;
	assign rdy_s1    = !v_s2 || rdy_s2;
	assign req_ready = !v_s1 || rdy_s1;
	assign cfg_ready = 1'b1;
	assign phase_ok  = 32'(req.phase) < PHASES;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q   <= RST_PERIOD_TICKS;
			off_tick_q <= RST_OFF_TICK;
			min_on_q   <= RST_MIN_ON_TICKS;
			min_off_q  <= RST_MIN_OFF_TICKS;
			flat_thr_q <= RST_FLAT_THRESHOLD;
		end else if (cfg_valid) begin
			case (cfg_idx_t'(cfg_index))
				CFG_PERIOD_TICKS:   period_q   <= cfg_data;
				CFG_OFF_TICK:       off_tick_q <= cfg_data;
				CFG_MIN_ON_TICKS:   min_on_q   <= cfg_data;
				CFG_MIN_OFF_TICKS:  min_off_q  <= cfg_data;
				CFG_FLAT_THRESHOLD: flat_thr_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Stage 1: register the request, drop out-of-range phases
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (req_ready)
			v_s1 <= req_valid && phase_ok;
	end

	always_ff @(posedge clk) begin
		if (req_ready && req_valid)
			req_s1 <= req;
	end

	// Compute on-time counts over the available and the full period
	assign full   = TICK_BITS'(period_q) - 1'b1;
	assign avail  = full - TICK_BITS'(req_s1.dead_hs_to_ls) - TICK_BITS'(req_s1.dead_ls_to_hs);
	assign p_ch_a = PW'(avail) * PW'(req_s1.duty_high);
	assign p_cl_a = PW'(avail) * PW'(req_s1.duty_low);
	assign p_ch_f = PW'(full) * PW'(req_s1.duty_high);
	assign p_cl_f = PW'(full) * PW'(req_s1.duty_low);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s2 <= 1'b0;
		else if (rdy_s1)
			v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && v_s1) begin
			req_s2  <= req_s1;
			ch_a_s2 <= p_ch_a[PW-2:16];
			cl_a_s2 <= p_cl_a[PW-2:16];
			ch_f_s2 <= p_ch_f[PW-2:16];
			cl_f_s2 <= p_cl_f[PW-2:16];
		end
	end

	// Stage 2: drop short pulses, then detect flat-high sides
	assign tmax_t       = TICK_BITS'(off_tick_q);
	assign dec.int_low  = CW'(ch_a_s2) < CW'(min_on_q);
	assign ch1          = dec.int_low ? '0 : ch_a_s2;
	assign cl1          = dec.int_low ? cl_f_s2 : cl_a_s2;
	assign dec.int_high = CW'(cl1) < CW'(min_on_q);
	assign cl2          = dec.int_high ? '0 : cl1;
	assign ch2          = dec.int_high ? ch_f_s2 : ch1;
	assign dec.flat_hs  = CW'(ch2) >= CW'(flat_thr_q);
	assign dec.flat_ls  = CW'(cl2) >= CW'(flat_thr_q);
	assign ch3          = dec.flat_hs ? tmax_t : ch2;
	assign cl3          = dec.flat_ls ? tmax_t : cl2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s3 <= 1'b0;
		else if (rdy_s2)
			v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && v_s2) begin
			req_s3 <= req_s2;
			ch_s3  <= ch3;
			cl_s3  <= cl3;
			dec_s3 <= dec;
		end
	end

	// Stage 3: place edges using the phase's stored mode
	assign ph_s3 = PH_BITS'(req_s3.phase);
	assign prev  = bridge_state_q[ph_s3];

	hbges_edge_calc #(
		.TICK_BITS(TICK_BITS)
	) u_edge_calc (
		.req      (req_s3),
		.ch       (ch_s3),
		.cl       (cl_s3),
		.dec      (dec_s3),
		.prev     (prev),
		.off_tick (off_tick_q),
		.min_off  (min_off_q),
		.rsp      (rsp_d)
	);

	// Update the per-phase mode as the result leaves stage 3
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PHASES; i++)
				bridge_state_q[i] <= BM_DISABLED;
		end else if (rdy_s3 && v_s3) begin
			bridge_state_q[ph_s3] <= bm_t'(rsp_d.bridge_mode);
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rsp_valid_q <= 1'b0;
		else if (rdy_s3)
			rsp_valid_q <= v_s3;
	end

	always_ff @(posedge clk) begin
		if (rdy_s3 && v_s3)
			rsp_q <= rsp_d;
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

@@ hw/rtl/hbges_edge_calc.sv @@
module hbges_edge_calc #(
	parameter int TICK_BITS = 16
) (
	input  hbges_pkg::req_t      req,
	input  logic [TICK_BITS-1:0] ch,
	input  logic [TICK_BITS-1:0] cl,
	input  hbges_pkg::dec_t      dec,
	input  hbges_pkg::bm_t       prev,
	input  logic [15:0]          off_tick,
	input  logic [15:0]          min_off,
	output hbges_pkg::rsp_t      rsp
);
	import hbges_pkg::*;

	logic [TICK_BITS-1:0] d_hl;
	logic [TICK_BITS-1:0] d_lh;
	logic [TICK_BITS-1:0] h_a;
	logic [TICK_BITS-1:0] h_b;
	logic [TICK_BITS-1:0] h_c;
	logic [TICK_BITS-1:0] l_a;
	logic [TICK_BITS-1:0] l_b;
	logic [TICK_BITS-1:0] l_c;
	logic [15:0]          tmax;
	logic [15:0]          lead_hs;
	logic [15:0]          lead_ls;
	logic [15:0]          hr;
	logic [15:0]          hf;
	logic [15:0]          lr;
	logic [15:0]          lf;
	bm_t                  ns;

	assign d_hl = TICK_BITS'(req.dead_hs_to_ls);
	assign d_lh = TICK_BITS'(req.dead_ls_to_hs);
	assign tmax = 16'(TICK_BITS'(off_tick));

	// Chain the edges for high-side led periods
	assign h_a = d_lh + ch;
	assign h_b = (ch != '0) ? h_a + d_hl : h_a;
	assign h_c = h_b + cl;

	// Chain the edges for low-side led periods
	assign l_a = d_hl + cl;
	assign l_b = (cl != '0) ? l_a + d_lh : l_a;
	assign l_c = l_b + ch;

	// Delay the flat turn-on by the larger of the dead time and min_off when leaving regular PWM
	assign lead_hs = ({4'd0, req.dead_ls_to_hs} > min_off) ? {4'd0, req.dead_ls_to_hs} : min_off;
	assign lead_ls = ({4'd0, req.dead_hs_to_ls} > min_off) ? {4'd0, req.dead_hs_to_ls} : min_off;

	// Pick the reported mode: later checks win
	always_comb begin
		ns = BM_REGULAR;
		if (dec.int_low)
			ns = BM_INT_LOW;
		if (dec.int_high)
			ns = BM_INT_HIGH;
		if (dec.flat_hs)
			ns = BM_FLAT_HS;
		if (dec.flat_ls)
			ns = BM_FLAT_LS;
	end

	// Place edges, apply the flat, dropped-pulse and zero-duty overrides
	always_comb begin
		hr = tmax;
		hf = tmax;
		lr = tmax;
		lf = tmax;
		case (mode_t'(req.mode))
			MODE_HS_LED: begin
				hr = {4'd0, req.dead_ls_to_hs};
				hf = 16'(h_a);
				lr = 16'(h_b);
				lf = 16'(h_c);
				if (dec.flat_hs) begin
					hr = (prev == BM_REGULAR) ? lead_hs : 16'd0;
					hf = tmax;
					lr = tmax;
					lf = tmax;
				end else if (dec.flat_ls) begin
					lr = 16'd0;
					lf = tmax;
					hr = tmax;
					hf = tmax;
				end else if (dec.int_low) begin
					hr = tmax;
					hf = tmax;
				end else if (dec.int_high) begin
					lr = tmax;
					lf = tmax;
				end
				if (req.duty_high == '0) begin
					hr = tmax;
					hf = tmax;
				end
				if (req.duty_low == '0) begin
					lr = tmax;
					lf = tmax;
				end
			end
			MODE_LS_LED: begin
				lr = {4'd0, req.dead_hs_to_ls};
				lf = 16'(l_a);
				hr = 16'(l_b);
				hf = 16'(l_c);
				if (dec.flat_ls) begin
					lr = (prev == BM_REGULAR) ? lead_ls : 16'd0;
					lf = tmax;
					hr = tmax;
					hf = tmax;
				end else if (dec.flat_hs) begin
					hr = 16'd0;
					hf = tmax;
					lr = tmax;
					lf = tmax;
				end else if (dec.int_high) begin
					lr = tmax;
					lf = tmax;
				end else if (dec.int_low) begin
					hr = tmax;
					hf = tmax;
				end
				if (req.duty_high == '0) begin
					hr = tmax;
					hf = tmax;
				end
				if (req.duty_low == '0) begin
					lr = tmax;
					lf = tmax;
				end
			end
			default: begin
				hr = tmax;
				hf = tmax;
				lr = tmax;
				lf = tmax;
			end
		endcase
	end

	always_comb begin
		rsp.phase_out   = req.phase;
		rsp.hs_rise     = hr;
		rsp.hs_fall     = hf;
		rsp.ls_rise     = lr;
		rsp.ls_fall     = lf;
		rsp.bridge_mode = ((req.mode == MODE_HS_LED) || (req.mode == MODE_LS_LED)) ?
			ns : BM_DISABLED;
	end

endmodule

@@ hw/rtl/hbges_checker.sv @@
module hbges_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            rsp_valid,
	input logic            rsp_ready,
	input hbges_pkg::rsp_t rsp
);
	import hbges_pkg::*;

	// Hold a stalled response
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("response changed while stalled");

	// Park every edge at the same tick when disabled
	a_disabled_parked: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.bridge_mode == BM_DISABLED |->
			rsp.hs_rise == rsp.hs_fall && rsp.hs_fall == rsp.ls_rise &&
			rsp.ls_rise == rsp.ls_fall)
		else $error("disabled bridge with distinct edges");

	// Keep the low side and the high-side fall parked in flat high-side mode
	a_flat_hs: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.bridge_mode == BM_FLAT_HS |->
			rsp.hs_fall == rsp.ls_rise && rsp.ls_rise == rsp.ls_fall)
		else $error("flat high-side edges not parked");

	// Drop the short pulse completely in intermittent modes
	a_intermittent: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.bridge_mode == BM_INT_LOW || rsp.bridge_mode == BM_INT_HIGH) |->
			(rsp.bridge_mode == BM_INT_LOW && rsp.hs_rise == rsp.hs_fall) ||
			(rsp.bridge_mode == BM_INT_HIGH && rsp.ls_rise == rsp.ls_fall))
		else $error("dropped pulse still has width");

endmodule

bind halfbridge_gate_edge_scheduler hbges_checker u_hbges_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);

@@ test/gate_edge_checker.sv @@
`timescale 1ns / 1ps

module gate_edge_checker #(
	parameter int PHASES = 3
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                req_valid,
	input  logic                                req_ready,
	input  hbges_pkg::req_t                     req,
	input  logic                                rsp_valid,
	input  logic                                rsp_ready,
	input  hbges_pkg::rsp_t                     rsp,
	input  logic                                cfg_valid,
	input  logic                                cfg_ready,
	input  logic [hbges_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [15:0]                         cfg_data,
	output int                                  errors,
	output int                                  pending,
	output int                                  results_seen
);
	import hbges_pkg::*;

	// Shadow copy of the configuration and of each phase's last bridge mode
	logic [15:0] period_ticks;
	logic [15:0] off_tick;
	logic [15:0] min_on_ticks;
	logic [15:0] min_off_ticks;
	logic [15:0] flat_threshold;
	bm_t         phase_mode [PHASES];

	rsp_t edges_due [$];
	rsp_t want;

	// On-time count: floor(span * duty / 2^16), wrapped to the tick width
	function automatic logic [15:0] duty_count(logic [15:0] span, logic [16:0] duty);
		logic [32:0] prod;
		prod = 33'(span) * 33'(duty);
		return prod[31:16];
	endfunction

	// Work out the edges of one period from the request and the phase's last mode
	function automatic rsp_t predict_edges(req_t r, bm_t prev);
		logic [15:0] tmax, full, avail, ch, cl, t, dhl, dlh;
		logic [15:0] hr, hf, lr, lf;
		logic        fl_h, fl_l, fh_h, fh_l;
		bm_t         ns;
		rsp_t        o;
		tmax  = off_tick;
		dhl   = 16'(r.dead_hs_to_ls);
		dlh   = 16'(r.dead_ls_to_hs);
		full  = period_ticks - 16'd1;
		avail = period_ticks - 16'd1 - dhl - dlh;
		ch    = duty_count(avail, r.duty_high);
		cl    = duty_count(avail, r.duty_low);
		fl_h  = 1'b0;
		fl_l  = 1'b0;
		fh_h  = 1'b0;
		fh_l  = 1'b0;
		ns    = BM_REGULAR;
		if (r.mode != MODE_HS_LED && r.mode != MODE_LS_LED) begin
			// Park every edge while the bridge is off
			ns = BM_DISABLED;
			hr = tmax;
			hf = tmax;
			lr = tmax;
			lf = tmax;
		end else begin
			// Drop pulses shorter than the driver allows, spend the period on the other side
			if (ch < min_on_ticks) begin
				ns   = BM_INT_LOW;
				ch   = '0;
				fl_h = 1'b1;
				cl   = duty_count(full, r.duty_low);
			end
			if (cl < min_on_ticks) begin
				ns   = BM_INT_HIGH;
				cl   = '0;
				fl_l = 1'b1;
				ch   = duty_count(full, r.duty_high);
			end
			// Hold a switch on for the whole period once its count is near full
			if (ch >= flat_threshold) begin
				ns   = BM_FLAT_HS;
				fh_h = 1'b1;
				ch   = tmax;
			end
			if (cl >= flat_threshold) begin
				ns   = BM_FLAT_LS;
				fh_l = 1'b1;
				cl   = tmax;
			end
			if (r.mode == MODE_HS_LED) begin
				t  = dlh;
				hr = t;
				t  = t + ch;
				hf = t;
				if (ch != '0)
					t = t + dhl;
				lr = t;
				t  = t + cl;
				lf = t;
				if (fh_h) begin
					hr = (prev == BM_REGULAR) ?
						((dlh > min_off_ticks) ? dlh : min_off_ticks) : 16'd0;
					hf = tmax;
					lr = tmax;
					lf = tmax;
				end else if (fh_l) begin
					lr = '0;
					lf = tmax;
					hr = tmax;
					hf = tmax;
				end else if (fl_h) begin
					hr = tmax;
					hf = tmax;
				end else if (fl_l) begin
					lr = tmax;
					lf = tmax;
				end
			end else begin
				t  = dhl;
				lr = t;
				t  = t + cl;
				lf = t;
				if (cl != '0)
					t = t + dlh;
				hr = t;
				t  = t + ch;
				hf = t;
				if (fh_l) begin
					lr = (prev == BM_REGULAR) ?
						((dhl > min_off_ticks) ? dhl : min_off_ticks) : 16'd0;
					lf = tmax;
					hr = tmax;
					hf = tmax;
				end else if (fh_h) begin
					hr = '0;
					hf = tmax;
					lr = tmax;
					lf = tmax;
				end else if (fl_l) begin
					lr = tmax;
					lf = tmax;
				end else if (fl_h) begin
					hr = tmax;
					hf = tmax;
				end
			end
			// A zero duty silences its side regardless of the decisions above
			if (r.duty_high == '0) begin
				hr = tmax;
				hf = tmax;
			end
			if (r.duty_low == '0) begin
				lr = tmax;
				lf = tmax;
			end
		end
		o.phase_out   = r.phase;
		o.hs_rise     = hr;
		o.hs_fall     = hf;
		o.ls_rise     = lr;
		o.ls_fall     = lf;
		o.bridge_mode = ns;
		return o;
	endfunction

	task automatic check_field(string name, logic [15:0] exp_v, logic [15:0] got_v);
		if (got_v !== exp_v) begin
			errors++;
			$display("%0t: %s mismatch, expected %0d got %0d", $time, name, exp_v, got_v);
		end
	endtask

	// Compare responses first, then apply writes and queue predictions for new requests
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_ticks   = RST_PERIOD_TICKS;
			off_tick       = RST_OFF_TICK;
			min_on_ticks   = RST_MIN_ON_TICKS;
			min_off_ticks  = RST_MIN_OFF_TICKS;
			flat_threshold = RST_FLAT_THRESHOLD;
			foreach (phase_mode[i])
				phase_mode[i] = BM_DISABLED;
			edges_due.delete();
			pending = 0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (edges_due.size() == 0) begin
					errors++;
					$display("%0t: response for phase %0d with none expected, got %h",
						$time, rsp.phase_out, rsp);
				end else begin
					want = edges_due.pop_front();
					results_seen++;
					check_field("phase_out", want.phase_out, rsp.phase_out);
					check_field("hs_rise", want.hs_rise, rsp.hs_rise);
					check_field("hs_fall", want.hs_fall, rsp.hs_fall);
					check_field("ls_rise", want.ls_rise, rsp.ls_rise);
					check_field("ls_fall", want.ls_fall, rsp.ls_fall);
					check_field("bridge_mode", want.bridge_mode, rsp.bridge_mode);
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_PERIOD_TICKS:   period_ticks = cfg_data;
					CFG_OFF_TICK:       off_tick = cfg_data;
					CFG_MIN_ON_TICKS:   min_on_ticks = cfg_data;
					CFG_MIN_OFF_TICKS:  min_off_ticks = cfg_data;
					CFG_FLAT_THRESHOLD: flat_threshold = cfg_data;
					default: ;
				endcase
			end
			// Drop requests for an absent phase without a prediction
			if (req_valid && req_ready && req.phase < PHASES) begin
				want = predict_edges(req, phase_mode[req.phase]);
				phase_mode[req.phase] = bm_t'(want.bridge_mode);
				edges_due.push_back(want);
			end
			pending = edges_due.size();
		end
	end

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps

module tb;
	import hbges_pkg::*;

	localparam int PHASES = 3;
	localparam int ITEMS_PER_SETTING = 180;
	localparam int SETTINGS_COUNT = 10;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    req_valid = 1'b0;
	logic                    req_ready;
	req_t                    req = '0;
	logic                    rsp_valid;
	logic                    rsp_ready = 1'b0;
	rsp_t                    rsp;
	logic                    cfg_valid = 1'b0;
	logic                    cfg_ready;
	logic [CFG_IDX_BITS-1:0] cfg_index = '0;
	logic [15:0]             cfg_data = '0;

	int chk_errors;
	int chk_pending;
	int chk_results;

	int sent = 0;
	int dropped = 0;
	int reg_writes = 0;
	int burst_left = 1;
	int stall_style = 0;
	int style_left = 0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	halfbridge_gate_edge_scheduler #(
		.PHASES    (PHASES),
		.TICK_BITS (16)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	gate_edge_checker #(
		.PHASES (PHASES)
	) chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_ready    (req_ready),
		.req          (req),
		.rsp_valid    (rsp_valid),
		.rsp_ready    (rsp_ready),
		.rsp          (rsp),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.errors       (chk_errors),
		.pending      (chk_pending),
		.results_seen (chk_results)
	);

	// Stall the response side in stretches: always ready, mostly ready, mostly stalled, periodic
	always @(posedge clk) begin
		if (style_left == 0) begin
			stall_style <= $urandom_range(0, 3);
			style_left  <= $urandom_range(20, 200);
		end else begin
			style_left <= style_left - 1;
		end
		case (stall_style)
			0:       rsp_ready <= 1'b1;
			1:       rsp_ready <= ($urandom_range(0, 3) != 0);
			2:       rsp_ready <= ($urandom_range(0, 3) == 0);
			default: rsp_ready <= (style_left % 3 != 0);
		endcase
	end

	function automatic req_t mk(int dh, int dl, mode_t m, int ph, int dhl, int dlh);
		req_t r;
		r.duty_high     = 17'(dh);
		r.duty_low      = 17'(dl);
		r.mode          = m;
		r.phase         = 2'(ph);
		r.dead_hs_to_ls = 12'(dhl);
		r.dead_ls_to_hs = 12'(dlh);
		return r;
	endfunction

	// Favor the duty corners: off, full, near full, tiny, above one
	function automatic int pick_duty();
		case ($urandom_range(0, 9))
			0:       return 0;
			1:       return 65536;
			2:       return 65536 - $urandom_range(0, 3000);
			3:       return $urandom_range(0, 4000);
			4:       return $urandom_range(65537, 131071);
			default: return $urandom_range(0, 65536);
		endcase
	endfunction

	function automatic int pick_dead();
		return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 63);
	endfunction

	function automatic req_t rand_req();
		mode_t m;
		case ($urandom_range(0, 9))
			0:       m = MODE_OFF;
			1:       m = MODE_OFF_HI;
			2, 3, 4, 5: m = MODE_HS_LED;
			default: m = MODE_LS_LED;
		endcase
		return mk(pick_duty(), pick_duty(), m,
			($urandom_range(0, 9) == 0) ? 3 : $urandom_range(0, PHASES - 1),
			pick_dead(), pick_dead());
	endfunction

	// Hold the request until taken, then maybe end the burst with a gap
	task automatic send_req(req_t r);
		int gap;
		req       <= r;
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
		sent++;
		if (r.phase >= PHASES)
			dropped++;
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120) :
				$urandom_range(1, 20);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [15:0] value);
		cfg_index <= idx;
		cfg_data  <= value;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		reg_writes++;
	endtask

	// Wait for every queued response, then let dropped requests leave the pipe
	task automatic drain();
		req_valid <= 1'b0;
		do @(posedge clk); while (chk_pending != 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic apply_setting(int p, int o, int mn, int mf, int th);
		write_reg(CFG_PERIOD_TICKS, 16'(p));
		write_reg(CFG_OFF_TICK, 16'(o));
		write_reg(CFG_MIN_ON_TICKS, 16'(mn));
		write_reg(CFG_MIN_OFF_TICKS, 16'(mf));
		write_reg(CFG_FLAT_THRESHOLD, 16'(th));
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		req_t r;
		int   n;
		int   p, o, mn, mf, th;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: off modes, zero duties, wrapping duties and dead times
		send_req(mk(32768, 26214, MODE_HS_LED, 0, 10, 12));
		send_req(mk(32768, 26214, MODE_LS_LED, 1, 10, 12));
		send_req(mk(40000, 20000, MODE_OFF, 2, 5, 5));
		send_req(mk(40000, 20000, MODE_OFF_HI, 0, 5, 5));
		send_req(mk(0, 30000, MODE_HS_LED, 1, 7, 9));
		send_req(mk(30000, 0, MODE_LS_LED, 2, 7, 9));
		send_req(mk(65536, 65536, MODE_HS_LED, 2, 0, 0));
		send_req(mk(131071, 131071, MODE_LS_LED, 0, 4095, 4095));
		send_req(mk(20000, 20000, MODE_HS_LED, 3, 1, 1));
		// Dead times that sum to the period wrap the span to all ones: flat after regular
		send_req(mk(30000, 30000, MODE_HS_LED, 0, 10, 20));
		send_req(mk(65536, 30000, MODE_HS_LED, 0, 400, 600));
		send_req(mk(65536, 30000, MODE_HS_LED, 0, 400, 600));
		send_req(mk(30000, 30000, MODE_LS_LED, 1, 10, 20));
		send_req(mk(30000, 65536, MODE_LS_LED, 1, 700, 300));
		drain();

		// Short period with minimum pulse limits: dropped pulses and flat periods
		apply_setting(200, 200, 20, 30, 150);
		send_req(mk(5000, 40000, MODE_HS_LED, 0, 5, 5));
		send_req(mk(40000, 5000, MODE_LS_LED, 1, 5, 5));
		send_req(mk(5000, 5000, MODE_HS_LED, 2, 5, 5));
		send_req(mk(30000, 30000, MODE_HS_LED, 0, 5, 5));
		send_req(mk(65000, 30000, MODE_HS_LED, 0, 5, 5));
		send_req(mk(30000, 30000, MODE_LS_LED, 1, 40, 5));
		send_req(mk(30000, 65000, MODE_LS_LED, 1, 40, 5));
		send_req(mk(65536, 65536, MODE_HS_LED, 2, 0, 0));
		send_req(mk(65536, 30000, MODE_LS_LED, 0, 5, 5));
		send_req(mk(65536, 65536, MODE_LS_LED, 2, 0, 0));
		drain();

		for (int k = 0; k < SETTINGS_COUNT; k++) begin
			case (k)
				0: begin
					p = 1000; o = 1000; mn = $urandom_range(0, 40);
					mf = $urandom_range(0, 80); th = p - $urandom_range(5, 80);
				end
				1, 8: begin
					p = $urandom_range(50, 400); o = p; mn = $urandom_range(0, p / 8);
					mf = $urandom_range(0, p / 4); th = p - $urandom_range(2, p / 6);
				end
				2: begin
					p = 0; o = $urandom_range(0, 65535); mn = $urandom_range(0, 2000);
					mf = $urandom_range(0, 4095); th = $urandom_range(30000, 65535);
				end
				3: begin
					p = 65535; o = 65535; mn = 0; mf = 65535; th = 65000;
				end
				4: begin
					p = $urandom_range(100, 2000); o = 0; mn = 65535; mf = 0; th = 65535;
				end
				5: begin
					p = 1; o = 1; mn = 0; mf = 0; th = 0;
				end
				6: begin
					p = $urandom_range(1, 65535); o = $urandom_range(0, 65535);
					mn = $urandom_range(0, 65535); mf = $urandom_range(0, 65535);
					th = $urandom_range(0, 65535);
				end
				7: begin
					p = $urandom_range(20, 120); o = p; mn = $urandom_range(1, 10);
					mf = $urandom_range(0, 30); th = p - $urandom_range(1, 10);
				end
				default: begin
					p = 65535; o = $urandom_range(0, 65535); mn = $urandom_range(0, 500);
					mf = $urandom_range(0, 4095); th = $urandom_range(60000, 65535);
				end
			endcase
			// An unmapped register index must leave the settings alone
			if (k == 6)
				write_reg(CFG_IDX_BITS'(CFG_FLAT_THRESHOLD) + CFG_IDX_BITS'($urandom_range(1, 3)),
					16'($urandom_range(0, 65535)));
			apply_setting(p, o, mn, mf, th);

			n = 0;
			while (n < ITEMS_PER_SETTING) begin
				r = rand_req();
				if ($urandom_range(0, 3) == 0) begin
					// Lead in with a plain period on one phase, then push one side toward full on
					r.mode      = $urandom_range(0, 1) ? MODE_HS_LED : MODE_LS_LED;
					r.phase     = 2'($urandom_range(0, PHASES - 1));
					r.duty_high = 17'($urandom_range(10000, 50000));
					r.duty_low  = 17'($urandom_range(10000, 50000));
					send_req(r);
					n++;
					if ($urandom_range(0, 1))
						r.duty_high = 17'(65536 - $urandom_range(0, 1500));
					else
						r.duty_low = 17'(65536 - $urandom_range(0, 1500));
				end
				send_req(r);
				n++;
			end
			drain();
		end

		$display("Covered %0d requests (%0d to an absent phase), %0d register writes,",
			sent, dropped, reg_writes);
		$display("and %0d responses compared field by field over %0d settings.",
			chk_results, SETTINGS_COUNT + 2);
		if (chk_errors == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	initial begin
		#2000000;
		$display("Timed out with %0d responses outstanding", chk_pending);
		$display("FAILED: results differ");
		$finish;
	end

endmodule
